### rtl/refraction_vector_unit_core_assert.svh
// ---------------------------------------------------------------------------
// refraction vector unit assertion macros
// shared property forms, sampled on i_clk and disabled during i_rst_n
// ---------------------------------------------------------------------------
`ifndef REFRACTION_VECTOR_UNIT_CORE_ASSERT_SVH
`define REFRACTION_VECTOR_UNIT_CORE_ASSERT_SVH

// condition holds at every edge
`define RVU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle of the antecedent
`define RVU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/rvu_pkg.sv
// ---------------------------------------------------------------------------
// rvu_pkg
// widths, constants and the side payload carried through the root pipeline
// ---------------------------------------------------------------------------
package rvu_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 20;
    localparam int RD_W     = 35;
    localparam int RINC_W   = 33;
    localparam int REFL_W   = 23;
    localparam int RAD_W    = 40;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQ_STAGES = RAD_W / 2;

    // main pipeline stages and the stage that feeds the root pipeline
    localparam int NST      = 9;
    localparam int SQ_AT    = 5;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic                       tir;
        logic                       d_neg;
        logic signed [RD_W-1:0]     rd;
        logic [2:0][IN_W-1:0]       n;
        logic [2:0][RINC_W-1:0]     rinc;
        logic [2:0][REFL_W-1:0]     refl;
    } t_side;

endpackage

### rtl/rvu_sqrt.sv
// ---------------------------------------------------------------------------
// rvu_sqrt
// pipelined integer square root, one root bit per stage, floor result,
// side payload travels alongside with the valid bits
// ---------------------------------------------------------------------------
`include "refraction_vector_unit_core_assert.svh"

module rvu_sqrt import rvu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [SQ_STAGES-1:0] r_vld;
    logic [SQ_STAGES-1:0] w_adv;
    logic [REM_W-1:0]     r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]    r_q    [SQ_STAGES];
    logic [RAD_W-1:0]     r_rad  [SQ_STAGES];
    t_side                r_side [SQ_STAGES];

    genvar j;
    generate
        for (j = 0; j < SQ_STAGES; j++) begin : g_stage
            logic              w_vld_in;
            logic [REM_W-1:0]  w_rem_in;
            logic [ROOT_W-1:0] w_q_in;
            logic [RAD_W-1:0]  w_rad_in;
            t_side             w_side_in;
            logic [REM_W+1:0]  w_cat;
            logic [REM_W+1:0]  w_trial;
            logic [REM_W+1:0]  w_diff;
            logic [REM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_q;

            if (j == 0) begin : g_first
                assign w_vld_in  = i_valid;
                assign w_rem_in  = '0;
                assign w_q_in    = '0;
                assign w_rad_in  = i_rad;
                assign w_side_in = i_side;
            end else begin : g_next
                assign w_vld_in  = r_vld[j-1];
                assign w_rem_in  = r_rem[j-1];
                assign w_q_in    = r_q[j-1];
                assign w_rad_in  = r_rad[j-1];
                assign w_side_in = r_side[j-1];
            end

            if (j == SQ_STAGES - 1) begin : g_last
                assign w_adv[j] = !r_vld[j] || i_ready;
            end else begin : g_mid
                assign w_adv[j] = !r_vld[j] || w_adv[j+1];
            end

            always_comb begin
                w_cat   = {w_rem_in, w_rad_in[2*(SQ_STAGES-1-j)+1 -: 2]};
                w_trial = {2'b00, w_q_in, 2'b01};
                w_diff  = w_cat - w_trial;
                if (w_cat >= w_trial) begin
                    n_rem = w_diff[REM_W-1:0];
                    n_q   = {w_q_in[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem = w_cat[REM_W-1:0];
                    n_q   = {w_q_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (w_adv[j]) begin
                    r_vld[j] <= w_vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[j]) begin
                    r_rem[j]  <= n_rem;
                    r_q[j]    <= n_q;
                    r_rad[j]  <= w_rad_in;
                    r_side[j] <= w_side_in;
                end
            end
        end
    endgenerate

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_root  = r_q[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];

    logic [REM_W-1:0] w_rem_lim;
    assign w_rem_lim = {1'b0, r_q[SQ_STAGES-1], 1'b0};

    `RVU_ASSERT_IMP(a_rem_bound, o_valid, r_rem[SQ_STAGES-1] <= w_rem_lim, "root remainder too large")
    `RVU_ASSERT_IMP(a_tir_zero_root, o_valid && o_side.tir, o_root == '0, "root not zero on reflection")

endmodule

### rtl/refraction_vector_unit_core.sv
// ---------------------------------------------------------------------------
// refraction_vector_unit_core
// snell refraction of a q2.14 direction about a q2.14 normal, q6.14 result,
// total internal reflection falls back to mirror reflection, saturating
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | i_valid / o_ready   | i_normal_*, i_incident_*, i_index_ratio
//  output  | o_valid / i_ready   | o_out_*, o_total_reflect, o_saturated
//
//  one transfer per cycle sustained while i_ready is high: nine arithmetic
//  stages plus a 20 stage root pipeline, one root bit per stage
//  reset clears only the stage valid bits
//  a stage holds only while full and its successor holds, so bubbles close
//  up and o_ready stays high whenever i_ready is high
// ---------------------------------------------------------------------------
`include "refraction_vector_unit_core_assert.svh"

module refraction_vector_unit_core import rvu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [IN_W-1:0]  i_normal_x,
    input  logic signed [IN_W-1:0]  i_normal_y,
    input  logic signed [IN_W-1:0]  i_normal_z,
    input  logic signed [IN_W-1:0]  i_incident_x,
    input  logic signed [IN_W-1:0]  i_incident_y,
    input  logic signed [IN_W-1:0]  i_incident_z,
    input  logic [IN_W-1:0]         i_index_ratio,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_out_x,
    output logic signed [OUT_W-1:0] o_out_y,
    output logic signed [OUT_W-1:0] o_out_z,
    output logic                    o_total_reflect,
    output logic                    o_saturated
);

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    logic              w_sq_ready;
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_sq_root;
    t_side             w_sq_side;

    // stage 0: products
    logic signed [31:0]     r0_pni [3];
    logic [31:0]            r0_prr;
    logic [2:0][IN_W-1:0]   r0_n;
    logic [2:0][IN_W-1:0]   r0_inc;
    logic [IN_W-1:0]        r0_r;
    // stage 1: rounded dot and ratio square
    logic signed [18:0]     r1_d;
    logic [18:0]            r1_r2;
    logic [2:0][IN_W-1:0]   r1_n;
    logic [2:0][IN_W-1:0]   r1_inc;
    logic [IN_W-1:0]        r1_r;
    // stage 2: second products
    logic [35:0]            r2_d2;
    logic signed [RD_W-1:0] r2_rd;
    logic signed [RD_W-1:0] r2_dn [3];
    logic [2:0][RINC_W-1:0] r2_rinc;
    logic [18:0]            r2_r2;
    logic                   r2_dneg;
    logic [2:0][IN_W-1:0]   r2_n;
    logic [2:0][IN_W-1:0]   r2_inc;
    // stage 3: one minus d squared, reflection result
    logic signed [36:0]     r3_t;
    logic [18:0]            r3_r2;
    t_side                  r3_side;
    // stage 4: ratio term of k
    logic signed [54:0]     r4_kp;
    t_side                  r4_side;
    // stage 5: k and radicand
    logic [RAD_W-1:0]       r5_rad;
    t_side                  r5_side;
    // stage 6: coefficient c
    logic signed [36:0]     r6_c;
    t_side                  r6_side;
    // stage 7: c times normal
    logic signed [52:0]     r7_cn [3];
    t_side                  r7_side;
    // stage 8: output register
    logic [2:0][OUT_W-1:0]  r8_out;
    logic                   r8_tir;
    logic                   r8_sat;

    // advance chain
    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            if (k == SQ_AT) begin
                w_adv[k] = !r_vld[k] || w_sq_ready;
            end else begin
                w_adv[k] = !r_vld[k] || w_adv[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_adv[k]) begin
                    if (k == 0) begin
                        r_vld[k] <= i_valid;
                    end else if (k == SQ_AT + 1) begin
                        r_vld[k] <= w_sq_valid;
                    end else begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    end

    // stage 0
    logic [2:0][IN_W-1:0] w_n_in;
    logic [2:0][IN_W-1:0] w_inc_in;
    assign w_n_in   = {i_normal_z, i_normal_y, i_normal_x};
    assign w_inc_in = {i_incident_z, i_incident_y, i_incident_x};

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int j = 0; j < 3; j++) begin
                r0_pni[j] <= $signed(w_n_in[j]) * $signed(w_inc_in[j]);
            end
            r0_prr <= i_index_ratio * i_index_ratio;
            r0_n   <= w_n_in;
            r0_inc <= w_inc_in;
            r0_r   <= i_index_ratio;
        end
    end

    // stage 1
    logic signed [33:0] w_dot;
    logic [32:0]        w_rr;
    assign w_dot = 34'(r0_pni[0]) + 34'(r0_pni[1]) + 34'(r0_pni[2]) + 34'sd8192;
    assign w_rr  = 33'(r0_prr) + 33'd8192;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_d   <= w_dot[32:14];
            r1_r2  <= w_rr[32:14];
            r1_n   <= r0_n;
            r1_inc <= r0_inc;
            r1_r   <= r0_r;
        end
    end

    // stage 2
    logic signed [37:0] w_dd;
    assign w_dd = r1_d * r1_d;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_d2 <= w_dd[35:0];
            r2_rd <= $signed({1'b0, r1_r}) * r1_d;
            for (int j = 0; j < 3; j++) begin
                r2_dn[j]   <= $signed(r1_n[j]) * r1_d;
                r2_rinc[j] <= RINC_W'($signed({1'b0, r1_r})) * RINC_W'($signed(r1_inc[j]));
            end
            r2_r2   <= r1_r2;
            r2_dneg <= r1_d[18];
            r2_n    <= r1_n;
            r2_inc  <= r1_inc;
        end
    end

    // stage 3
    logic signed [36:0] w_rv [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_rv[j] = (37'(r2_dn[j]) <<< 1) - (37'($signed(r2_inc[j])) <<< 14)
                    + 37'sd8192;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_t          <= 37'sd268435456 - $signed({1'b0, r2_d2});
            r3_r2         <= r2_r2;
            r3_side.tir   <= 1'b0;
            r3_side.d_neg <= r2_dneg;
            r3_side.rd    <= r2_rd;
            r3_side.n     <= r2_n;
            r3_side.rinc  <= r2_rinc;
            for (int j = 0; j < 3; j++) begin
                r3_side.refl[j] <= w_rv[j][36:14];
            end
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_kp   <= $signed({1'b0, r3_r2}) * r3_t;
            r4_side <= r3_side;
        end
    end

    // stage 5
    logic signed [55:0] w_k;
    t_side              n_side;
    assign w_k = 56'sh400_0000_0000 - 56'(r4_kp);

    always_comb begin
        n_side     = r4_side;
        n_side.tir = w_k[55];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_rad  <= w_k[55] ? '0 : w_k[53:14];
            r5_side <= n_side;
        end
    end

    rvu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[SQ_AT]),
        .o_ready (w_sq_ready),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_valid (w_sq_valid),
        .i_ready (w_adv[SQ_AT+1]),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // stage 6
    logic signed [36:0] w_root28;
    assign w_root28 = $signed({3'b000, w_sq_root, 14'd0});

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_c    <= w_sq_side.d_neg ? 37'(w_sq_side.rd) + w_root28
                                       : 37'(w_sq_side.rd) - w_root28;
            r6_side <= w_sq_side;
        end
    end

    // stage 7
    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            for (int j = 0; j < 3; j++) begin
                r7_cn[j] <= r6_c * $signed(r6_side.n[j]);
            end
            r7_side <= r6_side;
        end
    end

    // stage 8: round, select, clamp
    logic signed [53:0]    w_v   [3];
    logic signed [25:0]    w_sel [3];
    logic [2:0][OUT_W-1:0] n_out;
    logic                  n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            w_v[j] = 54'(r7_cn[j]) - (54'($signed(r7_side.rinc[j])) <<< 14)
                   + 54'sd134217728;
            w_sel[j] = r7_side.tir ? 26'($signed(r7_side.refl[j])) : w_v[j][53:28];
            if (w_sel[j] > 26'(OUT_MAX)) begin
                n_out[j] = OUT_MAX;
                n_sat    = 1'b1;
            end else if (w_sel[j] < 26'(OUT_MIN)) begin
                n_out[j] = OUT_MIN;
                n_sat    = 1'b1;
            end else begin
                n_out[j] = w_sel[j][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r8_out <= n_out;
            r8_tir <= r7_side.tir;
            r8_sat <= n_sat;
        end
    end

    assign o_ready         = w_adv[0];
    assign o_valid         = r_vld[NST-1];
    assign o_out_x         = r8_out[0];
    assign o_out_y         = r8_out[1];
    assign o_out_z         = r8_out[2];
    assign o_total_reflect = r8_tir;
    assign o_saturated     = r8_sat;

    logic w_clamped;
    assign w_clamped = o_out_x == OUT_MAX || o_out_x == OUT_MIN || o_out_y == OUT_MAX
                    || o_out_y == OUT_MIN || o_out_z == OUT_MAX || o_out_z == OUT_MIN;

    `RVU_ASSERT_ALWAYS(a_ready_follows, !i_ready || o_ready, "input stalled while output free")
    `RVU_ASSERT_IMP(a_sat_at_limit, o_valid && o_saturated, w_clamped, "saturated with no clamp")

endmodule

### tb/sv/rvu_tb_pkg.sv
// ---------------------------------------------------------------------------
// rvu_tb_pkg
// ray and direction records, the refraction predictor and a scoreboard that
// pairs each accepted ray with its predicted direction, in order
// ---------------------------------------------------------------------------
package rvu_tb_pkg;

    import rvu_pkg::*;

    typedef logic [2:0][IN_W-1:0] t_vec3;

    typedef struct packed {
        t_vec3           nrm;
        t_vec3           inc;
        logic [IN_W-1:0] ratio;
    } t_ray;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] comp;
        logic                  tir;
        logic                  sat;
    } t_dir;

    function automatic t_dir predict_refraction(t_ray ray);
        longint nv[3];
        longint iv[3];
        longint r, dot, d, r2, k, root28, c, v;
        longint unsigned rad, root, cand;
        t_dir res;
        res = '0;
        r = longint'(ray.ratio);
        for (int j = 0; j < 3; j++) begin
            nv[j] = longint'($signed(ray.nrm[j]));
            iv[j] = longint'($signed(ray.inc[j]));
        end
        dot = nv[0] * iv[0] + nv[1] * iv[1] + nv[2] * iv[2];
        d = (dot + 8192) >>> 14;
        r2 = (r * r + 8192) >>> 14;
        k = (longint'(1) <<< 42) - r2 * ((longint'(1) <<< 28) - d * d);
        res.tir = (k < 0);
        if (!res.tir) begin
            rad = $unsigned(k) >> 14;
            root = 0;
            for (int b = 23; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                if (cand * cand <= rad)
                    root = cand;
            end
            root28 = longint'(root) * 16384;
            c = r * d + ((d >= 0) ? -root28 : root28);
        end
        for (int j = 0; j < 3; j++) begin
            if (!res.tir)
                v = (c * nv[j] - r * iv[j] * 16384 + (longint'(1) <<< 27)) >>> 28;
            else
                v = (2 * d * nv[j] - iv[j] * 16384 + 8192) >>> 14;
            // clamp to the q6.14 range
            if (v > longint'(OUT_MAX)) begin
                v = longint'(OUT_MAX);
                res.sat = 1'b1;
            end else if (v < longint'(OUT_MIN)) begin
                v = longint'(OUT_MIN);
                res.sat = 1'b1;
            end
            res.comp[j] = v[OUT_W-1:0];
        end
        return res;
    endfunction

    class snell_checker;
        t_dir expected_dirs[$];
        int   errors;
        int   rays;
        int   checked;
        int   n_tir;
        int   n_sat;

        function void note_ray(t_ray ray);
            expected_dirs.push_back(predict_refraction(ray));
            rays++;
        endfunction

        function int pending();
            return expected_dirs.size();
        endfunction

        function void check_direction(t_dir got);
            t_dir  want;
            string axis[3];
            axis = '{"out_x", "out_y", "out_z"};
            if (expected_dirs.size() == 0) begin
                $error("result transfer with no ray outstanding");
                errors++;
                return;
            end
            want = expected_dirs.pop_front();
            checked++;
            n_tir += want.tir;
            n_sat += want.sat;
            for (int j = 0; j < 3; j++) begin
                if (got.comp[j] !== want.comp[j]) begin
                    $error("%s: expected %0d, actual %0d", axis[j],
                           $signed(want.comp[j]), $signed(got.comp[j]));
                    errors++;
                end
            end
            if (got.tir !== want.tir) begin
                $error("total_reflect: expected %0b, actual %0b", want.tir, got.tir);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %0b, actual %0b", want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

endpackage

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// refraction vector unit testbench: directed edge rays, then random rays,
// with bursty input traffic and a stalling receiver, checked in order
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rvu_pkg::*;
    import rvu_tb_pkg::*;

    localparam int N_RANDOM    = 1700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    i_ready = 1'b0;
    logic signed [IN_W-1:0]  i_normal_x = '0;
    logic signed [IN_W-1:0]  i_normal_y = '0;
    logic signed [IN_W-1:0]  i_normal_z = '0;
    logic signed [IN_W-1:0]  i_incident_x = '0;
    logic signed [IN_W-1:0]  i_incident_y = '0;
    logic signed [IN_W-1:0]  i_incident_z = '0;
    logic [IN_W-1:0]         i_index_ratio = '0;
    logic                    o_ready;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_out_x;
    logic signed [OUT_W-1:0] o_out_y;
    logic signed [OUT_W-1:0] o_out_z;
    logic                    o_total_reflect;
    logic                    o_saturated;

    snell_checker sb = new();

    int cycles;
    int burst_left;
    int rx_cycle;
    int stall_left;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    refraction_vector_unit_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_normal_z      (i_normal_z),
        .i_incident_x    (i_incident_x),
        .i_incident_y    (i_incident_y),
        .i_incident_z    (i_incident_z),
        .i_index_ratio   (i_index_ratio),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_total_reflect (o_total_reflect),
        .o_saturated     (o_saturated)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: rotates through always ready, random, long stalls, alternate
    always @(posedge i_clk) begin : rx_pattern
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            rx_cycle++;
            case ((rx_cycle / 256) % 4)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: begin
                    if (stall_left > 0) begin
                        stall_left--;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
                default: rdy = rx_cycle[0];
            endcase
        end
        i_ready <= rdy;
    end

    always @(posedge i_clk) begin : result_monitor
        t_dir got;
        if (i_rst_n && o_valid && i_ready) begin
            got.comp[0] = o_out_x;
            got.comp[1] = o_out_y;
            got.comp[2] = o_out_z;
            got.tir     = o_total_reflect;
            got.sat     = o_saturated;
            sb.check_direction(got);
        end
    end

    function int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 48);
        return $urandom_range(1, 9);
    endfunction

    function automatic t_ray make_ray(int nx, int ny, int nz, int ix, int iy, int iz,
                                      int r);
        t_ray ray;
        ray.nrm[0] = nx[IN_W-1:0];
        ray.nrm[1] = ny[IN_W-1:0];
        ray.nrm[2] = nz[IN_W-1:0];
        ray.inc[0] = ix[IN_W-1:0];
        ray.inc[1] = iy[IN_W-1:0];
        ray.inc[2] = iz[IN_W-1:0];
        ray.ratio  = r[IN_W-1:0];
        return ray;
    endfunction

    function automatic t_vec3 random_unit();
        real   c[3];
        real   len;
        int    q;
        t_vec3 u;
        for (int j = 0; j < 3; j++)
            c[j] = real'(int'($urandom_range(0, 65536)) - 32768) / 32768.0;
        len = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
        if (len < 0.01) begin
            c = '{0.0, 0.0, 1.0};
            len = 1.0;
        end
        for (int j = 0; j < 3; j++) begin
            q = int'(c[j] / len * 16384.0);
            u[j] = q[IN_W-1:0];
        end
        return u;
    endfunction

    function automatic t_ray random_ray();
        t_ray         ray;
        int           kind;
        int           v;
        logic [127:0] rnd;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            rnd = {$urandom(), $urandom(), $urandom(), $urandom()};
            ray = t_ray'(rnd[$bits(t_ray)-1:0]);
        end else if (kind < 9) begin
            ray.nrm   = random_unit();
            ray.inc   = random_unit();
            ray.ratio = IN_W'($urandom_range(8192, 40960));
        end else begin
            for (int j = 0; j < 3; j++) begin
                v = int'($urandom_range(0, 400)) - 200;
                ray.nrm[j] = v[IN_W-1:0];
                v = int'($urandom_range(0, 400)) - 200;
                ray.inc[j] = v[IN_W-1:0];
            end
            case ($urandom_range(0, 3))
                0: ray.ratio = '0;
                1: ray.ratio = 16'd16384;
                2: ray.ratio = '1;
                default: ray.ratio = IN_W'($urandom());
            endcase
        end
        return ray;
    endfunction

    // called just after a rising edge; returns just after the accepting edge, or after the gap that follows it
    task automatic send_ray(t_ray ray, int gap);
        i_valid       <= 1'b1;
        i_normal_x    <= ray.nrm[0];
        i_normal_y    <= ray.nrm[1];
        i_normal_z    <= ray.nrm[2];
        i_incident_x  <= ray.inc[0];
        i_incident_y  <= ray.inc[1];
        i_incident_z  <= ray.inc[2];
        i_index_ratio <= ray.ratio;
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_ray(ray);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_ray edge_rays[$];

        // straight through, slower medium, above critical angle, critical exactly
        edge_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0));
        edge_rays.push_back(make_ray(0, 0, 16384, 0, 0, -16384, 16384));
        edge_rays.push_back(make_ray(0, 0, 16384, 0, 0, -16384, 8192));
        edge_rays.push_back(make_ray(0, 0, 16384, 11585, 0, -11585, 24576));
        edge_rays.push_back(make_ray(0, 0, 16384, 16384, 0, 0, 16384));
        // dot product rounding to zero from below, then just below zero
        edge_rays.push_back(make_ray(-1, 0, 0, 8192, 0, 0, 12000));
        edge_rays.push_back(make_ray(-1, 0, 0, 8192, 0, 0, 20000));
        edge_rays.push_back(make_ray(-1, 0, 0, 8193, 0, 0, 12000));
        edge_rays.push_back(make_ray(0, 0, 16384, 0, 0, 16384, 16384));
        // extremes and saturation
        edge_rays.push_back(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        edge_rays.push_back(make_ray(-32768, -32768, -32768, 32767, 32767, 32767, 65535));
        edge_rays.push_back(make_ray(-32768, -32768, -32768, -32768, -32768, -32768,
                                     65535));
        edge_rays.push_back(make_ray(32767, 32767, 32767, -32768, -32768, -32768, 0));
        edge_rays.push_back(make_ray(0, 16384, 0, 16384, 0, 0, 65535));
        edge_rays.push_back(make_ray(16384, 0, 0, 0, -32768, 0, 0));
        edge_rays.push_back(make_ray(16384, 0, 0, -16384, 0, 0, 1));
        edge_rays.push_back(make_ray(0, 0, 16384, 0, 0, -16384, 32768));
        edge_rays.push_back(make_ray(0, 16384, 0, 16384, -1, 0, 16385));
        // unnormalised vectors and alternating bit patterns
        edge_rays.push_back(make_ray(8192, 8192, 8192, -4096, 2048, -16384, 16384));
        edge_rays.push_back(make_ray(16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA,
                                     16'hAAAA, 16'hAAAA));
        edge_rays.push_back(make_ray(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555,
                                     16'h5555, 16'h5555));

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_rays[i])
            send_ray(edge_rays[i], next_gap());
        drain();
        @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            send_ray(random_ray(), next_gap());
            if (i == N_RANDOM / 2) begin
                drain();
                @(posedge i_clk);
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d rays transferred, %0d directions checked", sb.rays, sb.checked);
        $display("%0d took total internal reflection, %0d saturated", sb.n_tir, sb.n_sat);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
